// ===== hdl/bptq_pkg.sv =====
// Shared types and constants of the bounded priority task queue.
// Holds codes, register indexes, the controller states and the cell control struct.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bptq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH   = 16;
  localparam int DEFAULT_HANDLE_BITS   = 16;
  localparam int DEFAULT_PRIORITY_BITS = 8;

  localparam int CAP_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;
  localparam int CNT_MAX_W = 9;
  localparam int IDX_MAX_W = 8;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 1'b1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [CNT_MAX_W-1:0] count;
    logic [IDX_MAX_W-1:0] pick;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/bptq_cell.sv =====
// One cell of the task chain: holds one queued task and one stage of the
// best-candidate scan. Depends on bptq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bptq_cell #(
  parameter int QUEUE_DEPTH   = bptq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int HANDLE_BITS   = bptq_pkg::DEFAULT_HANDLE_BITS,
  parameter int PRIORITY_BITS = bptq_pkg::DEFAULT_PRIORITY_BITS,
  parameter int CELL_INDEX    = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bptq_pkg::cell_ctrl_t             ctrl,
  input  logic [HANDLE_BITS-1:0]           push_handle,
  input  logic [PRIORITY_BITS-1:0]         push_priority,
  input  logic [HANDLE_BITS-1:0]           next_handle,
  input  logic [PRIORITY_BITS-1:0]         next_priority,
  output logic [HANDLE_BITS-1:0]           entry_handle,
  output logic [PRIORITY_BITS-1:0]         entry_priority,
  input  logic                             scan_in_found,
  input  logic [PRIORITY_BITS-1:0]         scan_in_priority,
  input  logic [HANDLE_BITS-1:0]           scan_in_handle,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   scan_in_index,
  output logic                             scan_out_found,
  output logic [PRIORITY_BITS-1:0]         scan_out_priority,
  output logic [HANDLE_BITS-1:0]           scan_out_handle,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   scan_out_index
);
  import bptq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic occupied;
  logic shift_in;
  logic load_new;
  logic take_own;

  assign occupied = CNT_MAX_W'(CELL_INDEX) < ctrl.count;
  assign shift_in = ctrl.pop && (IDX_MAX_W'(CELL_INDEX) >= ctrl.pick);
  assign load_new = ctrl.push && (CNT_MAX_W'(CELL_INDEX) == ctrl.count);

  // Strictly greater wins, so among equal priorities the older entry stays ahead.
  assign take_own = occupied && (!scan_in_found || (entry_priority > scan_in_priority));

  always_ff @(posedge clk) begin
    if (shift_in) begin
      entry_handle   <= next_handle;
      entry_priority <= next_priority;
    end else if (load_new) begin
      entry_handle   <= push_handle;
      entry_priority <= push_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out_found <= 1'b0;
    end else begin
      scan_out_found <= occupied || scan_in_found;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      scan_out_priority <= entry_priority;
      scan_out_handle   <= entry_handle;
      scan_out_index    <= IDX_W'(CELL_INDEX);
    end else begin
      scan_out_priority <= scan_in_priority;
      scan_out_handle   <= scan_in_handle;
      scan_out_index    <= scan_in_index;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bptq_ctrl.sv =====
// Request sequencer of the task queue: request and output registers, task count,
// scan wait counter and the cell control broadcast. Depends on bptq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bptq_ctrl #(
  parameter int QUEUE_DEPTH   = bptq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int HANDLE_BITS   = bptq_pkg::DEFAULT_HANDLE_BITS,
  parameter int PRIORITY_BITS = bptq_pkg::DEFAULT_PRIORITY_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [HANDLE_BITS-1:0]           task_handle,
  input  logic [PRIORITY_BITS-1:0]         task_priority,
  input  logic [bptq_pkg::CAP_W-1:0]       capacity_limit,
  input  logic                             priority_mode,
  input  logic [HANDLE_BITS-1:0]           head_handle,
  input  logic [PRIORITY_BITS-1:0]         head_priority,
  input  logic                             best_found,
  input  logic [HANDLE_BITS-1:0]           best_handle,
  input  logic [PRIORITY_BITS-1:0]         best_priority,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   best_index,
  output bptq_pkg::cell_ctrl_t             cell_ctrl,
  output logic [HANDLE_BITS-1:0]           req_handle,
  output logic [PRIORITY_BITS-1:0]         req_priority,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bptq_pkg::STATUS_W-1:0]    status,
  output logic [HANDLE_BITS-1:0]           popped_handle,
  output logic [PRIORITY_BITS-1:0]         popped_priority,
  output logic [bptq_pkg::OCC_W-1:0]       occupancy
);
  import bptq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t            state;
  state_t            state_next;
  logic              req_op;
  logic [IDX_W-1:0]  wait_count;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic              accept;
  logic              out_free;
  logic              commit;
  logic              is_full;
  logic              is_empty;
  logic              use_best;
  logic              push_ok;
  logic              pop_ok;
  status_t           result_status;
  logic [HANDLE_BITS-1:0]   result_handle;
  logic [PRIORITY_BITS-1:0] result_priority;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CNT_W'(QUEUE_DEPTH)) ||
                    (CMP_W'(count) >= CMP_W'(capacity_limit));
  assign is_empty = (count == '0);
  assign use_best = priority_mode && best_found;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((operation == OP_POP) && priority_mode && !is_empty) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SEARCH: begin
        if (wait_count == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer and the result of the held request.
  always_comb begin
    in_ready        = 1'b0;
    commit          = 1'b0;
    push_ok         = 1'b0;
    pop_ok          = 1'b0;
    result_status   = ST_PUSHED;
    result_handle   = '0;
    result_priority = '0;
    count_next      = count;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_FINISH: begin
        commit = out_free;
        if (req_op == OP_PUSH) begin
          if (is_full) begin
            result_status = ST_FULL;
          end else begin
            result_status = ST_PUSHED;
            push_ok       = 1'b1;
            count_next    = count + CNT_W'(1);
          end
        end else if (is_empty) begin
          result_status = ST_EMPTY;
        end else begin
          result_status   = ST_POPPED;
          pop_ok          = 1'b1;
          count_next      = count - CNT_W'(1);
          result_handle   = use_best ? best_handle : head_handle;
          result_priority = use_best ? best_priority : head_priority;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cell_ctrl.push  = commit && push_ok;
    cell_ctrl.pop   = commit && pop_ok;
    cell_ctrl.count = CNT_MAX_W'(count);
    cell_ctrl.pick  = use_best ? IDX_MAX_W'(best_index) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      wait_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        wait_count <= IDX_W'(QUEUE_DEPTH - 1);
      end else if (state == S_SEARCH) begin
        wait_count <= wait_count - IDX_W'(1);
      end
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op       <= operation;
      req_handle   <= task_handle;
      req_priority <= task_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status          <= result_status;
      popped_handle   <= result_handle;
      popped_priority <= result_priority;
      occupancy       <= OCC_W'(count_next);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bounded_priority_task_queue_core.sv =====
// Top level of the bounded priority task queue: configuration registers, the
// request sequencer and the chain of task cells. Depends on bptq_pkg, bptq_cell, bptq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// The queue holds up to QUEUE_DEPTH tasks in a chain of cells in arrival order,
// oldest in cell 0. Each transaction on the input channel is a push or a pop and
// yields exactly one transaction on the output channel with a status, the popped
// task (zero unless a task was popped) and the occupancy after the request. A push
// is rejected as full once the count reaches the smaller of capacity_limit and
// QUEUE_DEPTH; a pop of an empty queue reports empty. With priority_mode clear a
// pop takes the oldest task; with it set a pop takes the highest priority, oldest
// first among equals. One request is in work at a time. A push, a rejected request
// or a first-in first-out pop goes from S_IDLE to S_FINISH and is registered in the
// output register from there; a priority pop passes through S_SEARCH first, because the
// sequencer waits until the best candidate has traveled down the registered scan
// chain one cell per cycle. The input opens again once the result is registered,
// so a request holds the block until then, including any time a finished request
// waits on the output register. The input is taken while an earlier result still
// waits in the output register; a finished request waits only if that register is
// still occupied. Configuration is written over the APB port: register 0 at
// address 0 is capacity_limit (reset 16), register 1 at address 4 is priority_mode
// (reset 0). Registers are to change only between requests; the user must keep to
// this, as the block itself does not enforce it.
module bounded_priority_task_queue_core #(
  parameter int QUEUE_DEPTH   = bptq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int HANDLE_BITS   = bptq_pkg::DEFAULT_HANDLE_BITS,
  parameter int PRIORITY_BITS = bptq_pkg::DEFAULT_PRIORITY_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bptq_pkg::ADDR_W-1:0]     paddr,
  input  logic [bptq_pkg::DATA_W-1:0]     pwdata,
  output logic [bptq_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [HANDLE_BITS-1:0]          task_handle,
  input  logic [PRIORITY_BITS-1:0]        task_priority,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bptq_pkg::STATUS_W-1:0]   status,
  output logic [HANDLE_BITS-1:0]          popped_handle,
  output logic [PRIORITY_BITS-1:0]        popped_priority,
  output logic [bptq_pkg::OCC_W-1:0]      occupancy
);
  import bptq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic [CAP_W-1:0]     capacity_limit;
  logic                 priority_mode;
  logic [REG_IDX_W-1:0] reg_index;
  cell_ctrl_t           cell_ctrl;
  logic [HANDLE_BITS-1:0]   req_handle;
  logic [PRIORITY_BITS-1:0] req_priority;

  logic [HANDLE_BITS-1:0]   entry_handle   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] entry_priority [QUEUE_DEPTH];

  // Scan chain taps: tap 0 is the empty seed, tap QUEUE_DEPTH is the winner.
  logic                     scan_found    [QUEUE_DEPTH+1];
  logic [PRIORITY_BITS-1:0] scan_priority [QUEUE_DEPTH+1];
  logic [HANDLE_BITS-1:0]   scan_handle   [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]         scan_index    [QUEUE_DEPTH+1];

  // Configuration port. Writes complete in the access phase; no wait states.
  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAPACITY_RESET;
      priority_mode  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_CAPACITY: capacity_limit <= pwdata[CAP_W-1:0];
        REG_MODE:     priority_mode  <= pwdata[0];
        default:      priority_mode  <= priority_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CAPACITY: prdata = DATA_W'(capacity_limit);
      REG_MODE:     prdata = DATA_W'(priority_mode);
      default:      prdata = '0;
    endcase
  end

  bptq_ctrl #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HANDLE_BITS   (HANDLE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .task_handle     (task_handle),
    .task_priority   (task_priority),
    .capacity_limit  (capacity_limit),
    .priority_mode   (priority_mode),
    .head_handle     (entry_handle[0]),
    .head_priority   (entry_priority[0]),
    .best_found      (scan_found[QUEUE_DEPTH]),
    .best_handle     (scan_handle[QUEUE_DEPTH]),
    .best_priority   (scan_priority[QUEUE_DEPTH]),
    .best_index      (scan_index[QUEUE_DEPTH]),
    .cell_ctrl       (cell_ctrl),
    .req_handle      (req_handle),
    .req_priority    (req_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .popped_handle   (popped_handle),
    .popped_priority (popped_priority),
    .occupancy       (occupancy)
  );

  assign scan_found[0]    = 1'b0;
  assign scan_priority[0] = '0;
  assign scan_handle[0]   = '0;
  assign scan_index[0]    = '0;

  // The chain. On a pop every cell at or past the picked slot takes its upper
  // neighbor's task; a push lands in the cell whose index equals the count.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0]   up_handle;
    logic [PRIORITY_BITS-1:0] up_priority;

    if (i < QUEUE_DEPTH - 1) begin : g_inner
      assign up_handle   = entry_handle[i+1];
      assign up_priority = entry_priority[i+1];
    end else begin : g_last
      assign up_handle   = entry_handle[i];
      assign up_priority = entry_priority[i];
    end

    bptq_cell #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .HANDLE_BITS   (HANDLE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .CELL_INDEX    (i)
    ) u_cell (
      .clk               (clk),
      .rst               (rst),
      .ctrl              (cell_ctrl),
      .push_handle       (req_handle),
      .push_priority     (req_priority),
      .next_handle       (up_handle),
      .next_priority     (up_priority),
      .entry_handle      (entry_handle[i]),
      .entry_priority    (entry_priority[i]),
      .scan_in_found     (scan_found[i]),
      .scan_in_priority  (scan_priority[i]),
      .scan_in_handle    (scan_handle[i]),
      .scan_in_index     (scan_index[i]),
      .scan_out_found    (scan_found[i+1]),
      .scan_out_priority (scan_priority[i+1]),
      .scan_out_handle   (scan_handle[i+1]),
      .scan_out_index    (scan_index[i+1])
    );
  end

`ifndef NO_ASSERTIONS
  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in work");

  // A result that popped nothing carries a zero task.
  a_zero_task: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_POPPED)) |-> ((popped_handle == '0) && (popped_priority == '0)))
    else $error("non-pop transaction carries a task");

  // An empty report means the queue holds nothing.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_EMPTY)) |-> (occupancy == '0))
    else $error("empty transaction with nonzero occupancy");
`endif

endmodule

`default_nettype wire

// ===== dv/bounded_priority_task_queue_core_test.sv =====
// Self-checking testbench of bounded_priority_task_queue_core: directed and random push/pop
// traffic under several capacity and mode settings, checked against a queue predictor.
// Depends on bptq_pkg and the bounded_priority_task_queue_core RTL.
`timescale 1ns / 1ps

module bounded_priority_task_queue_core_test;
  import bptq_pkg::*;

  localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
  localparam int HANDLE_W    = DEFAULT_HANDLE_BITS;
  localparam int PRIO_W      = DEFAULT_PRIORITY_BITS;
  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 400000;

  // One expected result transaction.
  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic [OCC_W-1:0]    occupancy;
  } queue_result_t;

  // The scoreboard keeps its own copy of the queued tasks in arrival order, oldest first,
  // together with the two registers. Every accepted request adds exactly one expected
  // result; every result transaction is compared with the oldest one still waiting.
  class queue_scoreboard;
    logic [HANDLE_W-1:0] held_handles[$];
    logic [PRIO_W-1:0]   held_prios[$];
    logic [CAP_W-1:0]    capacity;
    logic                prio_first;
    queue_result_t       awaited[$];
    int unsigned         error_count;

    function new();
      capacity    = CAPACITY_RESET;
      prio_first  = 1'b0;
      error_count = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(op_t op, logic [HANDLE_W-1:0] handle,
                               logic [PRIO_W-1:0] prio);
      queue_result_t r;
      int            limit;
      int            pick;
      r.status    = ST_PUSHED;
      r.handle    = '0;
      r.prio      = '0;
      r.occupancy = '0;
      // A capacity beyond the physical depth behaves as the depth.
      limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
      if (op == OP_PUSH) begin
        if (held_handles.size() >= limit) begin
          r.status = ST_FULL;
        end else begin
          held_handles.push_back(handle);
          held_prios.push_back(prio);
        end
      end else if (held_handles.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // Strictly greater keeps the oldest task among equal priorities.
        pick = 0;
        if (prio_first) begin
          for (int i = 1; i < held_prios.size(); i++) begin
            if (held_prios[i] > held_prios[pick]) pick = i;
          end
        end
        r.status = ST_POPPED;
        r.handle = held_handles[pick];
        r.prio   = held_prios[pick];
        held_handles.delete(pick);
        held_prios.delete(pick);
      end
      r.occupancy = OCC_W'(held_handles.size());
      awaited.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] handle,
                               logic [PRIO_W-1:0] prio, logic [OCC_W-1:0] occ);
      queue_result_t e;
      if (awaited.size() == 0) begin
        $error("result with no request waiting: status %0d, handle %0h, occupancy %0d",
               st, handle, occ);
        error_count++;
        return;
      end
      e = awaited[0];
      awaited.delete(0);
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        error_count++;
      end
      if (handle !== e.handle) begin
        $error("popped_handle: expected %0h, actual %0h", e.handle, handle);
        error_count++;
      end
      if (prio !== e.prio) begin
        $error("popped_priority: expected %0h, actual %0h", e.prio, prio);
        error_count++;
      end
      if (occ !== e.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", e.occupancy, occ);
        error_count++;
      end
    endfunction
  endclass

  // All inputs start at known values; reset is held from time zero.
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                operation = OP_PUSH;
  logic [HANDLE_W-1:0] task_handle = '0;
  logic [PRIO_W-1:0]   task_priority = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] popped_handle;
  logic [PRIO_W-1:0]   popped_priority;
  logic [OCC_W-1:0]    occupancy;

  // Idle rates in percent per cycle for the request sender and the result receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  queue_scoreboard sb;

  bounded_priority_task_queue_core DUT (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .task_handle     (task_handle),
    .task_priority   (task_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .popped_handle   (popped_handle),
    .popped_priority (popped_priority),
    .occupancy       (occupancy)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // The receiver drops ready at random according to the current idle rate. Only one
  // nonblocking assignment per edge is made here, so there is no ordering hazard.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result transactions are sampled at the edge that completes them. Values read here are
  // the ones from before the edge, since both sides update with nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(status, popped_handle, popped_priority, occupancy);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Presents one request and returns at the edge where it is accepted. The request is
  // noted in the scoreboard right there. Valid is left high on return: the caller either
  // presents the next request in the same time step or drops valid with quiesce, so valid
  // never gets two assignments in one step.
  task automatic send_request(op_t op, logic [HANDLE_W-1:0] handle, logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    task_handle   <= handle;
    task_priority <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, handle, prio);
  endtask

  // Stops presenting requests and waits until every expected result has come back.
  // Each request yields a result, so the block is idle once nothing is outstanding;
  // a few extra cycles give the output register time to settle.
  task automatic quiesce(int unsigned extra_cycles);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // APB write: a setup phase, then an access phase that completes when pready is high.
  // The bus then goes idle before the task returns, so a back-to-back write starts in a later time step.
  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CAPACITY) sb.capacity = value[CAP_W-1:0];
    else sb.prio_first = value[0];
    @(posedge clk);
  endtask

  // Registers change only with no request in flight; queued tasks stay in place, which
  // exercises a capacity below the count and a mode change with tasks waiting.
  task automatic set_registers(logic [CAP_W-1:0] cap, logic mode);
    quiesce(4);
    write_register(REG_CAPACITY, DATA_W'(cap));
    write_register(REG_MODE, DATA_W'(mode));
  endtask

  // Random traffic in bursts. Each burst leans toward pushes, pops or neither, so the queue
  // fills to its capacity, drains to empty and wanders in between. Priorities are often
  // drawn from a tiny range to force ties, sometimes pinned to the extremes.
  task automatic run_random(int unsigned count);
    int unsigned         push_pct;
    op_t                 op;
    logic [PRIO_W-1:0]   prio;
    push_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      case ($urandom_range(3))
        0:       prio = PRIO_W'($urandom_range(3));
        1:       prio = $urandom_range(1) ? {PRIO_W{1'b1}} : '0;
        default: prio = PRIO_W'($urandom_range((1 << PRIO_W) - 1));
      endcase
      send_request(op, HANDLE_W'($urandom_range((1 << HANDLE_W) - 1)), prio);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first idle profile: sender idles a little, receiver a lot.
    send_idle_pct = 14;
    recv_idle_pct = 60;

    // Reset settings: full capacity, first-in first-out. Pop of an empty queue first,
    // then field extremes and a priority tie.
    send_request(OP_POP, '0, '0);
    send_request(OP_PUSH, 16'h0000, 8'h00);
    send_request(OP_PUSH, 16'hFFFF, 8'hFF);
    send_request(OP_PUSH, 16'h1234, 8'h07);
    send_request(OP_PUSH, 16'h5678, 8'hFF);
    send_request(OP_POP, '0, '0);

    // Switch to priority order with tasks waiting: the two equal top priorities must
    // come out oldest first, then the rest, then empty.
    set_registers(5'd16, 1'b1);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);

    // Small capacity: the third push is rejected as full.
    set_registers(5'd2, 1'b1);
    send_request(OP_PUSH, 16'hA5A5, 8'h01);
    send_request(OP_PUSH, 16'h5A5A, 8'h80);
    send_request(OP_PUSH, 16'h0F0F, 8'hFE);

    // Capacity dropped to zero below the count: pushes are rejected, queued tasks still pop.
    set_registers(5'd0, 1'b1);
    send_request(OP_PUSH, 16'hC3C3, 8'h55);
    send_request(OP_POP, '0, '0);
    send_request(OP_PUSH, 16'h3C3C, 8'hAA);
    send_request(OP_POP, '0, '0);
    send_request(OP_POP, '0, '0);

    // Random part. Settings cover the largest capacity field value (beyond the depth),
    // the depth itself, small values and zero, in both modes.
    set_registers(5'd16, 1'b0);
    run_random(300);
    set_registers(5'd31, 1'b1);
    run_random(300);

    // Second idle profile: sender idles a lot, receiver a little.
    send_idle_pct = 60;
    recv_idle_pct = 14;
    set_registers(5'd7, 1'b1);
    run_random(300);
    set_registers(5'd1, 1'b0);
    run_random(150);
    set_registers(5'd0, 1'b1);
    run_random(50);

    // Third profile: full throughput on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_registers(CAP_W'($urandom_range(1, DEPTH)), 1'b1);
    run_random(350);
    set_registers(5'd16, 1'b0);
    run_random(400);

    // The final wait is sized from the depth, since a priority pop waits for the whole scan chain.
    quiesce(DEPTH + 4);
    if (sb.error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bptq_pkg.sv
hdl/bptq_cell.sv
hdl/bptq_ctrl.sv
hdl/bounded_priority_task_queue_core.sv
dv/bounded_priority_task_queue_core_test.sv
